// File: rtl/one_shot_timer_bank_macros.svh
// Assertion macros shared by the timer bank RTL.
// Needs a clock named clk and a synchronous reset named rst in the using scope.
`ifndef ONE_SHOT_TIMER_BANK_MACROS_SVH
`define ONE_SHOT_TIMER_BANK_MACROS_SVH

// Same-cycle implication, checked outside reset
`define OTB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset
`define OTB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/otb_pkg.sv
// Shared types and constants of the one-shot timer bank.
// No dependencies.
`timescale 1ns / 1ps

package otb_pkg;

  typedef enum logic [1:0] {
    OP_START   = 2'd0,
    OP_RESTART = 2'd1,
    OP_STOP    = 2'd2,
    OP_TICK    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_STARTED   = 2'd0,
    KIND_RESTARTED = 2'd1,
    KIND_STOPPED   = 2'd2,
    KIND_EXPIRED   = 2'd3
  } kind_t;

  // at most this many expiries are reported by one tick
  localparam int RESULT_CAP = 16;
  localparam int CNT_W      = $clog2(RESULT_CAP + 1);

  localparam int TIMEOUT_W = 32;
  localparam int TLEFT_W   = 33;
  localparam int TAG_W     = 8;
  localparam int ELAPSED_W = 16;

  typedef struct packed {
    logic load;        // capture the accepted item
    logic find;        // test the slot at the scan index for a start
    logic find_last;   // scan index is the last slot
    logic rd_slot;     // read the stores at the addressed slot
    logic restart_wr;  // reload time left of the addressed slot
    logic stop;        // free the addressed slot
    logic tick_rd;     // read the slot at the scan index for a tick
    logic flush;       // send the held expiry as the final one
  } cmd_t;

  typedef struct packed {
    logic idx_active;  // slot at the scan index is in use
  } status_t;

endpackage

// File: rtl/otb_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module otb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/otb_ctrl.sv
// Controller of the timer bank: sequences start, restart, stop and tick.
// Depends on otb_pkg and one_shot_timer_bank_macros.svh.
`timescale 1ns / 1ps
`include "one_shot_timer_bank_macros.svh"

module otb_ctrl #(
  parameter int TIMER_SLOTS = 16,
  localparam int SLOT_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [1:0]       operation,
  input  otb_pkg::status_t st,
  output otb_pkg::cmd_t    cmd,
  output logic [SLOT_W-1:0] idx,
  output logic             busy
);
  import otb_pkg::*;

  localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(TIMER_SLOTS - 1);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_FIND  = 8'b0000_0010,
    S_RS_RD = 8'b0000_0100,
    S_RS_WR = 8'b0000_1000,
    S_STOP  = 8'b0001_0000,
    S_TICK  = 8'b0010_0000,
    S_DRAIN = 8'b0100_0000,
    S_FLUSH = 8'b1000_0000
  } state_t;

  state_t            state, state_next;
  logic [SLOT_W-1:0] idx_next;

  always_comb begin
    state_next = state;
    idx_next   = idx;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          idx_next = '0;
          case (operation)
            OP_START:   state_next = S_FIND;
            OP_RESTART: state_next = S_RS_RD;
            OP_STOP:    state_next = S_STOP;
            default:    state_next = S_TICK;
          endcase
        end
      end
      S_FIND: begin
        cmd.find      = 1'b1;
        cmd.find_last = (idx == LAST_IDX);
        if (!st.idx_active || idx == LAST_IDX) begin
          state_next = S_IDLE;
        end else begin
          idx_next = idx + SLOT_W'(1);
        end
      end
      S_RS_RD: begin
        cmd.rd_slot = 1'b1;
        state_next  = S_RS_WR;
      end
      S_RS_WR: begin
        cmd.restart_wr = 1'b1;
        state_next     = S_IDLE;
      end
      S_STOP: begin
        cmd.stop   = 1'b1;
        state_next = S_IDLE;
      end
      S_TICK: begin
        cmd.tick_rd = 1'b1;
        if (idx == LAST_IDX) begin
          state_next = S_DRAIN;
        end else begin
          idx_next = idx + SLOT_W'(1);
        end
      end
      S_DRAIN: begin
        state_next = S_FLUSH;
      end
      S_FLUSH: begin
        cmd.flush  = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  assign busy = (state != S_IDLE);

  `OTB_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
  `OTB_ASSERT_NXT(a_tick_advance, state == S_TICK && idx != LAST_IDX,
                  idx == $past(idx) + SLOT_W'(1), "tick scan skipped a slot")

endmodule

// File: rtl/otb_datapath.sv
// Datapath of the timer bank: slot stores, active bits, tick arithmetic, result register.
// Depends on otb_pkg, otb_ram and one_shot_timer_bank_macros.svh.
`timescale 1ns / 1ps
`include "one_shot_timer_bank_macros.svh"

module otb_datapath #(
  parameter int TIMER_SLOTS = 16,
  localparam int SLOT_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  otb_pkg::cmd_t                cmd,
  input  logic [SLOT_W-1:0]            idx,
  output otb_pkg::status_t             st,
  input  logic [3:0]                   timer_slot,
  input  logic signed [otb_pkg::TIMEOUT_W-1:0] timeout,
  input  logic [otb_pkg::TAG_W-1:0]    message_tag,
  input  logic [otb_pkg::ELAPSED_W-1:0] elapsed,
  output logic                         result_valid,
  output logic [1:0]                   result_kind,
  output logic [3:0]                   result_slot,
  output logic                         found,
  output logic [otb_pkg::TAG_W-1:0]    expired_tag,
  output logic                         last
);
  import otb_pkg::*;

  // captured item
  logic [3:0]                  slot_q;
  logic signed [TIMEOUT_W-1:0] timeout_q;
  logic [TAG_W-1:0]            tag_q;
  logic [ELAPSED_W-1:0]        elapsed_q;

  logic [TIMER_SLOTS-1:0] active;

  // addressed slot for restart and stop
  logic [SLOT_W+3:0] slot_wide;
  logic [SLOT_W-1:0] slot_addr;
  logic              slot_ok;

  // stores
  logic                      ram_we_start;
  logic                      tl_we;
  logic [SLOT_W-1:0]         tl_waddr;
  logic [TLEFT_W-1:0]        tl_wdata;
  logic [SLOT_W-1:0]         raddr;
  logic signed [TIMEOUT_W-1:0] reload_rdata;
  logic signed [TLEFT_W-1:0] tl_rdata;
  logic [TAG_W-1:0]          tag_rdata;

  // tick pipeline
  logic               proc_valid;
  logic [SLOT_W-1:0]  proc_idx;
  logic signed [TLEFT_W-1:0] new_tl;
  logic               proc_active;
  logic               expire;
  logic [CNT_W-1:0]   exp_cnt;
  logic               pend_valid;
  logic [3:0]         pend_slot;
  logic [TAG_W-1:0]   pend_tag;

  // result staging
  logic              emit;
  logic [1:0]        e_kind;
  logic [3:0]        e_slot;
  logic              e_found;
  logic [TAG_W-1:0]  e_tag;
  logic              e_last;
  logic [SLOT_W+3:0] idx_wide;
  logic [SLOT_W+3:0] proc_wide;

  assign slot_wide = (SLOT_W + 4)'(slot_q);
  assign slot_addr = slot_wide[SLOT_W-1:0];
  assign slot_ok   = (slot_wide < (SLOT_W + 4)'(TIMER_SLOTS)) && active[slot_addr];
  assign idx_wide  = (SLOT_W + 4)'(idx);
  assign proc_wide = (SLOT_W + 4)'(proc_idx);

  assign st.idx_active = active[idx];

  assign ram_we_start = cmd.find && !active[idx];
  assign raddr        = cmd.rd_slot ? slot_addr : idx;

  assign proc_active = proc_valid && active[proc_idx];
  assign new_tl      = tl_rdata - $signed({{(TLEFT_W - ELAPSED_W){1'b0}}, elapsed_q});
  assign expire      = proc_active && (new_tl[TLEFT_W-1] || new_tl == '0)
                       && (exp_cnt < CNT_W'(RESULT_CAP));

  always_comb begin
    tl_we    = 1'b0;
    tl_waddr = idx;
    tl_wdata = {timeout_q[TIMEOUT_W-1], timeout_q};
    if (ram_we_start) begin
      tl_we = 1'b1;
    end else if (cmd.restart_wr && slot_ok) begin
      tl_we    = 1'b1;
      tl_waddr = slot_addr;
      if (timeout_q[TIMEOUT_W-1]) begin
        tl_wdata = {reload_rdata[TIMEOUT_W-1], reload_rdata};
      end
    end else if (proc_active) begin
      tl_we    = 1'b1;
      tl_waddr = proc_idx;
      tl_wdata = new_tl;
    end
  end

  otb_ram #(.WIDTH(TIMEOUT_W), .DEPTH(TIMER_SLOTS)) u_reload (
    .clk   (clk),
    .we    (ram_we_start),
    .waddr (idx),
    .wdata (timeout_q),
    .raddr (raddr),
    .rdata (reload_rdata)
  );

  otb_ram #(.WIDTH(TLEFT_W), .DEPTH(TIMER_SLOTS)) u_tleft (
    .clk   (clk),
    .we    (tl_we),
    .waddr (tl_waddr),
    .wdata (tl_wdata),
    .raddr (raddr),
    .rdata (tl_rdata)
  );

  otb_ram #(.WIDTH(TAG_W), .DEPTH(TIMER_SLOTS)) u_tag (
    .clk   (clk),
    .we    (ram_we_start),
    .waddr (idx),
    .wdata (tag_q),
    .raddr (raddr),
    .rdata (tag_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      slot_q    <= timer_slot;
      timeout_q <= timeout;
      tag_q     <= message_tag;
      elapsed_q <= elapsed;
    end
    proc_idx <= idx;
    if (expire) begin
      pend_slot <= proc_wide[3:0];
      pend_tag  <= tag_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active     <= '0;
      proc_valid <= 1'b0;
      exp_cnt    <= '0;
      pend_valid <= 1'b0;
    end else begin
      proc_valid <= cmd.tick_rd;
      if (ram_we_start) begin
        active[idx] <= 1'b1;
      end else if (cmd.stop && slot_ok) begin
        active[slot_addr] <= 1'b0;
      end else if (expire) begin
        active[proc_idx] <= 1'b0;
      end
      if (cmd.load) begin
        exp_cnt    <= '0;
        pend_valid <= 1'b0;
      end else if (expire) begin
        exp_cnt    <= exp_cnt + CNT_W'(1);
        pend_valid <= 1'b1;
      end else if (cmd.flush) begin
        pend_valid <= 1'b0;
      end
    end
  end

  // An expiry is held back until the next expiry or the flush, so the final one can carry last.
  always_comb begin
    emit    = 1'b0;
    e_kind  = KIND_STARTED;
    e_slot  = '0;
    e_found = 1'b0;
    e_tag   = '0;
    e_last  = 1'b1;
    if (cmd.find) begin
      if (!active[idx]) begin
        emit    = 1'b1;
        e_slot  = idx_wide[3:0];
        e_found = 1'b1;
      end else if (cmd.find_last) begin
        emit = 1'b1;
      end
    end else if (cmd.restart_wr) begin
      emit    = 1'b1;
      e_kind  = KIND_RESTARTED;
      e_slot  = slot_q;
      e_found = slot_ok;
    end else if (cmd.stop) begin
      emit    = 1'b1;
      e_kind  = KIND_STOPPED;
      e_slot  = slot_q;
      e_found = slot_ok;
    end else if ((expire || cmd.flush) && pend_valid) begin
      emit    = 1'b1;
      e_kind  = KIND_EXPIRED;
      e_slot  = pend_slot;
      e_found = 1'b1;
      e_tag   = pend_tag;
      e_last  = cmd.flush;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= emit;
    end
    if (emit) begin
      result_kind <= e_kind;
      result_slot <= e_slot;
      found       <= e_found;
      expired_tag <= e_tag;
      last        <= e_last;
    end
  end

  `OTB_ASSERT_IMP(a_cap, 1'b1, exp_cnt <= CNT_W'(RESULT_CAP), "expiry count above cap")
  `OTB_ASSERT_NXT(a_flush_clears, cmd.flush, !pend_valid, "held expiry survived the flush")
  `OTB_ASSERT_IMP(a_non_expiry_last, result_valid && result_kind != KIND_EXPIRED, last,
                  "single result not marked last")

endmodule

// File: rtl/one_shot_timer_bank.sv
// Top level of the one-shot timer bank: controller plus datapath.
// Depends on otb_pkg, otb_ctrl and otb_datapath.
`timescale 1ns / 1ps

// A bank of TIMER_SLOTS single-shot timers driven by start/busy commands.
// An item is taken when start is high and busy low; each result shows for one
// cycle with result_valid and must be taken then, as the receiver cannot stall.
// After an item is taken, busy stays high while it is worked on, and the next
// item can be taken at the end of the first cycle with busy low. A start scans
// the active bits from slot 0 until it meets a free slot or the last slot;
// restart makes one read of the reload store before its write, and stop frees
// the addressed slot. A tick walks every slot once through the time-left store,
// one slot a cycle; its expiries come out in ascending slot order, the final
// one marked by last, and a tick with no expiry gives none. Each result is
// registered and appears in the cycle after the one that emits it.
module one_shot_timer_bank #(
  parameter int TIMER_SLOTS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           operation,
  input  logic [3:0]           timer_slot,
  input  logic signed [31:0]   timeout,
  input  logic [7:0]           message_tag,
  input  logic [15:0]          elapsed,
  output logic                 result_valid,
  output logic [1:0]           result_kind,
  output logic [3:0]           result_slot,
  output logic                 found,
  output logic [7:0]           expired_tag,
  output logic                 last
);
  import otb_pkg::*;

  localparam int SLOT_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;

  cmd_t              cmd;
  status_t           st;
  logic [SLOT_W-1:0] idx;

  otb_ctrl #(.TIMER_SLOTS(TIMER_SLOTS)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (operation),
    .st        (st),
    .cmd       (cmd),
    .idx       (idx),
    .busy      (busy)
  );

  otb_datapath #(.TIMER_SLOTS(TIMER_SLOTS)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .idx          (idx),
    .st           (st),
    .timer_slot   (timer_slot),
    .timeout      (timeout),
    .message_tag  (message_tag),
    .elapsed      (elapsed),
    .result_valid (result_valid),
    .result_kind  (result_kind),
    .result_slot  (result_slot),
    .found        (found),
    .expired_tag  (expired_tag),
    .last         (last)
  );

endmodule
